// ===== src/aesinv_pkg.sv =====
package aesinv_pkg;

	typedef struct packed {
		logic         func;
		logic [3:0]   round_index;
		logic [127:0] state;
	} item_t;

	localparam logic FUNC_KEY = 1'b0;
	localparam logic FUNC_DEC = 1'b1;

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
		8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
		8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
		8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
		8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
		8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
		8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
		8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
		8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
		8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
		8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
		8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
		8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
		8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
		8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
		8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
		8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
		8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
		8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
		8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
		8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
		8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
		8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
		8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
		8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
		8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
		8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
		8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
		8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
		8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
		8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
		8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte b of the state sits at bits [127-8b -: 8]
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int b);
		return s[127 - 8*b -: 8];
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [127:0] r;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		r = '0;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				a[k]  = get_byte(s, 4*c + k);
				x2[k] = xtime(a[k]);
				x4[k] = xtime(x2[k]);
				x8[k] = xtime(x4[k]);
				m9[k] = x8[k] ^ a[k];
				mb[k] = x8[k] ^ x2[k] ^ a[k];
				md[k] = x8[k] ^ x4[k] ^ a[k];
				me[k] = x8[k] ^ x4[k] ^ x2[k];
			end
			r[127 - 8*(4*c)     -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			r[127 - 8*(4*c + 1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			r[127 - 8*(4*c + 2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			r[127 - 8*(4*c + 3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		return r;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] r;
		r = '0;
		for (int rr = 0; rr < 4; rr++) begin
			for (int c = 0; c < 4; c++) begin
				r[127 - 8*(rr + 4*c) -: 8] =
					INV_SBOX[get_byte(s, rr + 4*((c - rr + 4) % 4))];
			end
		end
		return r;
	endfunction

endpackage

// ===== src/aesinv_round.sv =====
module aesinv_round #(
	parameter int ROUND = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [3:0]          rounds,
	input  logic                in_valid,
	input  aesinv_pkg::item_t   in_item,
	output logic                out_valid,
	output aesinv_pkg::item_t   out_item
);
	import aesinv_pkg::*;

	localparam logic [3:0] RND = 4'(ROUND);

	logic [127:0] key_q;
	logic [127:0] keyed;
	logic [127:0] mixed;
	item_t        nxt;
	logic         valid_s1;
	item_t        item_s1;

	// this stage owns its round key; a key beat updates it on its way through
	always_ff @(posedge clk) begin
		if (en && in_valid && in_item.func == FUNC_KEY && in_item.round_index == RND)
			key_q <= in_item.state;
	end

	always_comb begin
		keyed = in_item.state ^ key_q;
		mixed = (RND == rounds) ? keyed : inv_mix(keyed);
		nxt   = in_item;
		if (in_item.func == FUNC_DEC && RND <= rounds)
			nxt.state = inv_shift_sub(mixed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			item_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1))
		else $error("stage valid moved while stalled");
	a_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		rounds <= 4'd14)
		else $error("round count not saturated");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> valid_s1 == $past(in_valid))
		else $error("stage valid lost");
`endif
endmodule

// ===== src/aes_inverse_cipher.sv =====
// AES inverse cipher, one round per pipeline stage.
// Input stream s_axis: tuser = func, tdata = round_index, word_high, word_low.
// A beat with func 0 writes round key round_index (0..MAX_ROUNDS) of an
// already expanded schedule; it travels down the pipe and updates the key
// copy held by the stage that uses it, so it stays ordered with decrypts.
// A beat with func 1 decrypts a block and yields one beat on m_axis
// (tdata = plain_high, plain_low). Key writes yield no output beat.
// The pipe is an input register, MAX_ROUNDS round stages (stages past
// round_count pass the block through), and an output register that also
// adds key 0. One beat is accepted per cycle while m_axis is not stalled.
// round_count is written over APB at address 0; values above MAX_ROUNDS
// act as MAX_ROUNDS. Write it only while the pipe is empty.
// Reset clears all valid bits and sets round_count to 10; round keys are
// undefined until written.
// When m_axis stalls with a result waiting, the whole pipe holds and
// s_axis_tready drops; nothing is lost or repeated.
module aes_inverse_cipher #(
	parameter int MAX_ROUNDS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // round_index[3:0], word_high, word_low, zero pad
	input  logic         s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // plain_high[63:0], plain_low
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import aesinv_pkg::*;

	logic [3:0]   round_count_q;
	logic [3:0]   rounds;
	logic         en;
	logic         v    [MAX_ROUNDS + 1];
	item_t        it   [MAX_ROUNDS + 1];
	logic         v_in;
	item_t        it_in;
	logic [127:0] key0_q;
	logic         out_valid_q;
	logic [127:0] out_q;

	assign pready = 1'b1;
	assign prdata = {28'd0, round_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			round_count_q <= 4'd10;
		else if (psel && penable && pwrite && paddr == 3'd0)
			round_count_q <= pwdata[3:0];
	end

	assign rounds = (round_count_q > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : round_count_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	assign it_in.func        = s_axis_tuser;
	assign it_in.round_index = s_axis_tdata[3:0];
	assign it_in.state       = {s_axis_tdata[67:4], s_axis_tdata[131:68]};
	assign v_in              = s_axis_tvalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v[0] <= 1'b0;
		else if (en)
			v[0] <= v_in;
	end

	always_ff @(posedge clk) begin
		if (en)
			it[0] <= it_in;
	end

	for (genvar p = 1; p <= MAX_ROUNDS; p++) begin : g_round
		aesinv_round #(.ROUND(MAX_ROUNDS + 1 - p)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.rounds   (rounds),
			.in_valid (v[p-1]),
			.in_item  (it[p-1]),
			.out_valid(v[p]),
			.out_item (it[p])
		);
	end

	always_ff @(posedge clk) begin
		if (en && v[MAX_ROUNDS] && it[MAX_ROUNDS].func == FUNC_KEY &&
				it[MAX_ROUNDS].round_index == 4'd0)
			key0_q <= it[MAX_ROUNDS].state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= v[MAX_ROUNDS] && it[MAX_ROUNDS].func == FUNC_DEC;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_q <= it[MAX_ROUNDS].state ^ key0_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

`ifndef NO_ASSERTIONS
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_q)))
		else $error("result dropped during stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!out_valid_q || m_axis_tready))
		else $error("ready does not follow output stall");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rounds <= 4'(MAX_ROUNDS))
		else $error("round count above maximum");
`endif
endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import aesinv_pkg::*;

	localparam int MAX_R = 14;
	localparam int LAT = MAX_R + 2;

	typedef struct {
		logic        func;
		logic [3:0]  idx;
		logic [63:0] hi;
		logic [63:0] lo;
	} beat_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} plain_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [2:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	aes_inverse_cipher dut (.*);

	always #2 clk = ~clk;

	beat_t  pending_beats[$];
	plain_t plain_q[$];
	beat_t  cur_beat;
	logic [63:0] key_hi [MAX_R+1];
	logic [63:0] key_lo [MAX_R+1];
	logic [3:0]  rounds_cfg = 4'd10;
	logic [7:0]  inv_tab [256];
	int fails = 0;
	bit quiet = 0;
	bit hold_req = 0;

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic hb;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			hb = a[7];
			if (b[0]) p ^= a;
			a = {a[6:0], 1'b0};
			if (hb) a ^= 8'h1b;
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] bs;
		int e;
		r = 8'h01;
		bs = x;
		e = 254;
		while (e != 0) begin
			if (e & 1) r = gmul(r, bs);
			bs = gmul(bs, bs);
			e >>= 1;
		end
		return r;
	endfunction

	function automatic plain_t decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [127:0] kw;
		logic [127:0] blk;
		int nr;
		plain_t res;
		blk = {hi, lo};
		for (int b = 0; b < 16; b++) s[b] = blk[127-8*b -: 8];
		nr = (rounds_cfg > MAX_R) ? MAX_R : rounds_cfg;
		for (int i = nr; i > 0; i--) begin
			kw = {key_hi[i], key_lo[i]};
			for (int b = 0; b < 16; b++) s[b] ^= kw[127-8*b -: 8];
			if (i != nr) begin
				for (int c = 0; c < 4; c++) begin
					t[4*c]   = gmul(s[4*c], 8'hE) ^ gmul(s[4*c+1], 8'hB)
						^ gmul(s[4*c+2], 8'hD) ^ gmul(s[4*c+3], 8'h9);
					t[4*c+1] = gmul(s[4*c], 8'h9) ^ gmul(s[4*c+1], 8'hE)
						^ gmul(s[4*c+2], 8'hB) ^ gmul(s[4*c+3], 8'hD);
					t[4*c+2] = gmul(s[4*c], 8'hD) ^ gmul(s[4*c+1], 8'h9)
						^ gmul(s[4*c+2], 8'hE) ^ gmul(s[4*c+3], 8'hB);
					t[4*c+3] = gmul(s[4*c], 8'hB) ^ gmul(s[4*c+1], 8'hD)
						^ gmul(s[4*c+2], 8'h9) ^ gmul(s[4*c+3], 8'hE);
				end
				s = t;
			end
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					t[r + 4*c] = s[r + 4*((c - r + 4) & 3)];
			for (int b = 0; b < 16; b++) s[b] = inv_tab[t[b]];
		end
		kw = {key_hi[0], key_lo[0]};
		for (int b = 0; b < 16; b++) s[b] ^= kw[127-8*b -: 8];
		for (int b = 0; b < 16; b++) blk[127-8*b -: 8] = s[b];
		res.hi = blk[127:64];
		res.lo = blk[63:0];
		return res;
	endfunction

	// driver: hold a beat until taken, predict on acceptance
	int src_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (cur_beat.func == FUNC_KEY) begin
					if (cur_beat.idx <= MAX_R) begin
						key_hi[cur_beat.idx] = cur_beat.hi;
						key_lo[cur_beat.idx] = cur_beat.lo;
					end
				end else
					plain_q.push_back(decrypt_block(cur_beat.hi, cur_beat.lo));
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold
			end else if (src_gap > 0) begin
				src_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 19) == 0) begin
				src_gap = $urandom_range(1, 13) - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				cur_beat = pending_beats.pop_front();
				s_axis_tuser <= cur_beat.func;
				s_axis_tdata <= {4'h0, cur_beat.lo, cur_beat.hi, cur_beat.idx};
				s_axis_tvalid <= 1'b1;
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// monitor: random stalls plus one long hold-off on request
	int sink_gap = 0;
	int hold_left = 0;
	plain_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (plain_q.size() == 0) begin
					$error("unexpected output beat %h", m_axis_tdata);
					fails++;
				end else begin
					want = plain_q.pop_front();
					if (m_axis_tdata[63:0] !== want.hi) begin
						$error("plain_high expected %h actual %h", want.hi, m_axis_tdata[63:0]);
						fails++;
					end
					if (m_axis_tdata[127:64] !== want.lo) begin
						$error("plain_low expected %h actual %h", want.lo, m_axis_tdata[127:64]);
						fails++;
					end
				end
			end
			if (hold_req && hold_left == 0) begin
				hold_req = 0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 14) == 0) begin
				sink_gap = $urandom_range(1, 13) - 1;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rounds_cfg = data[3:0];
	endtask

	task automatic push_beat(input logic f, input logic [3:0] i, input logic [63:0] h,
			input logic [63:0] l);
		beat_t bt;
		bt.func = f;
		bt.idx = i;
		bt.hi = h;
		bt.lo = l;
		pending_beats.push_back(bt);
	endtask

	// wait until the last beat is taken and every result is out
	task automatic drain();
		wait (pending_beats.size() == 0);
		@(posedge clk);
		wait (!s_axis_tvalid);
		wait (plain_q.size() == 0);
		repeat (LAT + 4) @(posedge clk);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		int counts [9] = '{10, 12, 14, 0, 1, 11, 15, 13, 10};
		for (int v = 0; v < 256; v++) begin
			logic [7:0] x;
			x = 8'(v);
			inv_tab[v] = ginv({x[6:0], x[7]} ^ {x[4:0], x[7:5]} ^ {x[1:0], x[7:2]} ^ 8'h05);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// load every round key, extremes first
		push_beat(FUNC_KEY, 4'd0, '0, '0);
		push_beat(FUNC_KEY, 4'd1, '1, '1);
		for (int k = 2; k <= MAX_R; k++) push_beat(FUNC_KEY, 4'(k), rnd64(), rnd64());
		// out-of-range index is dropped
		push_beat(FUNC_KEY, 4'd15, '1, '1);
		push_beat(FUNC_DEC, 4'd0, '0, '0);
		push_beat(FUNC_DEC, 4'd15, '1, '1);
		push_beat(FUNC_DEC, 4'd5, 64'h0123456789abcdef, 64'hfedcba9876543210);
		push_beat(FUNC_DEC, 4'd0, rnd64(), rnd64());
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			apb_write(3'd0, counts[ph]);
			if (ph == 8) quiet = 1;
			for (int n = 0; n < 105; n++) begin
				if ($urandom_range(0, 7) == 0)
					push_beat(FUNC_KEY, 4'($urandom_range(0, 15)), rnd64(), rnd64());
				else
					push_beat(FUNC_DEC, 4'($urandom_range(0, 15)), rnd64(), rnd64());
			end
			if (ph == 1) hold_req = 1;
			drain();
		end

		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
src/aesinv_pkg.sv
src/aesinv_round.sv
src/aes_inverse_cipher.sv
dv/tb.sv
